FILE: design/bhq_pkg.sv
// shared constants, codes and types of the min-priority queue (a sorted chain of cells)
package bhq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAT_W   = 2;

  // request operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  // value returned by an extract from an empty queue
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic extract;
  } cell_ctl_t;

endpackage

FILE: design/bhq_req_if.sv
// request channel: operation and value with valid/ready
interface bhq_req_if
  import bhq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

FILE: design/bhq_rsp_if.sv
// result channel: minimum, status and entry count with valid/ready
interface bhq_rsp_if
  import bhq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] min_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, min_value, status, entry_count, input ready);
  modport sink   (input valid, min_value, status, entry_count, output ready);
endinterface

FILE: design/bhq_cell.sv
// one cell of the sorted chain: holds a value, keeps it or takes the new value or a neighbour's
module bhq_cell
  import bhq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic                     left_keep,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic                     occupied,
  output logic signed [DATA_W-1:0] value,
  output logic                     keep
);

  // an occupied cell not above the new value stays where it is
  assign keep = occupied && (value <= new_value);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!keep) begin
        value <= left_keep ? new_value : left_value;
      end
    end else if (ctl.extract) begin
      value <= right_value;
    end
  end

endmodule

FILE: design/binary_min_heap_queue_top.sv
// top level of the min-priority queue: cell chain, entry count and result register
//
//   channel  dir  transfer when          payload
//   req      in   req.valid & req.ready  operation, value
//   rsp      out  rsp.valid & rsp.ready  min_value, status, entry_count
//
// one request per cycle while req.ready is high: every cell compares and shifts
// in the same cycle, and the result is registered in the cycle after the transfer
// the smallest entry always sits in cell 0, in ascending order to the right
// rst is synchronous: it clears the entry count and the result valid only
// req.ready is low only while a result waits in the register and rsp.ready is low
module binary_min_heap_queue_top
  import bhq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  bhq_req_if.sink    req,
  bhq_rsp_if.source  rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // result register
  logic                     res_valid;
  logic signed [DATA_W-1:0] res_min;
  logic [STAT_W-1:0]        res_status;
  logic [CNT_W-1:0]         res_count;

  logic req_xfer;
  logic is_full;
  logic is_empty;
  cell_ctl_t ctl;

  // chain wiring
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_keep  [CAPACITY];

  // the result register frees up as soon as its content is taken
  assign req.ready = !res_valid || rsp.ready;
  assign req_xfer  = req.valid && req.ready;

  assign is_full  = (count >= CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  assign ctl.insert  = req_xfer && (req.operation == OP_INSERT) && !is_full;
  assign ctl.extract = req_xfer && (req.operation == OP_EXTRACT) && !is_empty;

  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.extract) begin
      count_next = count - CNT_W'(1);
    end
  end

  // row of cells, each looks at its left and right neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_keep;
    logic signed [DATA_W-1:0] right_value;
    logic                     occupied;

    if (i == 0) begin : g_head
      // on an insert, the head cell takes the new value whenever it does not keep its own
      assign left_value = req.value;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // nothing beyond the tail, its value is stale once count drops
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    assign occupied = (CNT_W'(i) < count);

    bhq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_value   (req.value),
      .left_value  (left_value),
      .left_keep   (left_keep),
      .right_value (right_value),
      .occupied    (occupied),
      .value       (cell_value[i]),
      .keep        (cell_keep[i])
    );
  end

  // entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_xfer) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each request transfer
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      res_count <= count_next;
      if (req.operation == OP_INSERT) begin
        res_min    <= '0;
        res_status <= is_full ? ST_OVERFLOW : ST_OK;
      end else if (is_empty) begin
        res_min    <= EMPTY_VALUE;
        res_status <= ST_EMPTY;
      end else begin
        res_min    <= cell_value[0];
        res_status <= ST_OK;
      end
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.min_value   = res_min;
  assign rsp.status      = res_status;
  assign rsp.entry_count = res_count;

`ifndef ASSERT_OFF
  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an insert into a queue with room adds exactly one entry
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && (req.operation == OP_INSERT) && !is_full)
    |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // the two front cells stay in ascending order
  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
    else $error("front cells out of order");

  // an empty extract reports the empty value and no entries
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY))
    |-> ((rsp.min_value == EMPTY_VALUE) && (rsp.entry_count == '0)))
    else $error("empty extract result malformed");
`endif

endmodule
